// File: hdl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  localparam int unsigned OPERAND_WIDTH_DEF = 32;
  localparam int unsigned MAG_W = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // one classified item, front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic        a_neg;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic        b_neg;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPG,    // operand reduction: gcd
    ST_OPDN,   // operand divide numerator
    ST_OPDD,   // operand divide denominator
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_RG,     // result gcd
    ST_RDN,
    ST_RDD,
    ST_OUT
  } bst_t;
endpackage
`default_nettype wire

// File: hdl/rau_front.sv
`default_nettype none
module rau_front
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);
  localparam int unsigned QD = 2;

  item_t      q_mem [QD];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push, pop;

  // sign-extend at OPERAND_WIDTH, then take magnitude
  function automatic logic [32:0] mag(input logic [31:0] raw);
    logic [31:0] v;
    logic        s;
    begin
      s = raw[OPERAND_WIDTH-1];
      v = {{(32-OPERAND_WIDTH){s}}, raw[OPERAND_WIDTH-1:0]};
      mag = {s, s ? 32'(-v) : v};
    end
  endfunction

  always_comb begin
    logic [32:0] an, ad, bn, bd;
    an = mag(in_tdata[31:0]);
    ad = mag(in_tdata[63:32]);
    bn = mag(in_tdata[95:64]);
    bd = mag(in_tdata[127:96]);
    cls.mode  = in_tuser;
    cls.a_neg = an[32] ^ ad[32];
    cls.a_num = an[31:0];
    cls.a_den = ad[31:0];
    cls.b_neg = bn[32] ^ bd[32];
    cls.b_num = bn[31:0];
    cls.b_den = bd[31:0];
  end

  assign in_tready = (cnt_r != 2'(QD));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = q_mem[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_mem[wp_r] <= cls;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue count overflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QD) && !pop |=> cnt_r == 2'(QD))
    else $error("full queue changed without pop");
  a_empty_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

// File: hdl/rau_gcd.sv
`default_nettype none
// binary gcd plus restoring divider, one step a cycle
module rau_gcd
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_g,
  input  wire logic        start_d,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic             done,
  output logic [63:0] res
);
  logic [63:0] u_r, u_nxt, v_r, v_nxt, q_r, q_nxt, rm_r, rm_nxt;
  logic [6:0]  k_r, k_nxt;
  logic        gbusy_r, gbusy_nxt, dbusy_r, dbusy_nxt, done_nxt, done_r;
  logic [64:0] trial;

  assign done = done_r;
  assign res  = q_r;

  always_comb begin
    u_nxt = u_r; v_nxt = v_r; q_nxt = q_r; rm_nxt = rm_r; k_nxt = k_r;
    gbusy_nxt = gbusy_r; dbusy_nxt = dbusy_r; done_nxt = 1'b0;
    trial = {rm_r, u_r[63]} - {1'b0, v_r};
    if (start_g) begin
      u_nxt = x; v_nxt = y; k_nxt = 7'd0; gbusy_nxt = 1'b1;
    end else if (start_d) begin
      u_nxt = x; v_nxt = y; rm_nxt = '0; q_nxt = '0; k_nxt = 7'd64; dbusy_nxt = 1'b1;
    end else if (gbusy_r) begin
      if (u_r == 0 || v_r == 0) begin
        q_nxt = (u_r | v_r) << k_r[5:0];
        gbusy_nxt = 1'b0; done_nxt = 1'b1;
      end else if (!u_r[0] && !v_r[0]) begin
        u_nxt = u_r >> 1; v_nxt = v_r >> 1; k_nxt = k_r + 7'd1;
      end else if (!u_r[0]) u_nxt = u_r >> 1;
      else if (!v_r[0]) v_nxt = v_r >> 1;
      else if (u_r >= v_r) u_nxt = (u_r - v_r) >> 1;
      else v_nxt = (v_r - u_r) >> 1;
    end else if (dbusy_r) begin
      u_nxt = u_r << 1;
      if (!trial[64]) begin
        rm_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rm_nxt = {rm_r[62:0], u_r[63]}; q_nxt = {q_r[62:0], 1'b0};
      end
      k_nxt = k_r - 7'd1;
      if (k_r == 7'd1) begin dbusy_nxt = 1'b0; done_nxt = 1'b1; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0; dbusy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      gbusy_r <= gbusy_nxt; dbusy_r <= dbusy_nxt; done_r <= done_nxt;
    end
    u_r <= u_nxt; v_r <= v_nxt; q_r <= q_nxt; rm_r <= rm_nxt; k_r <= k_nxt;
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(gbusy_r && dbusy_r))
    else $error("gcd and divide both busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !gbusy_r && !dbusy_r)
    else $error("done while busy");
  a_dstart: assert property (@(posedge clk) disable iff (!rst_n)
    start_d |=> dbusy_r && k_r == 7'd64)
    else $error("divide start lost");
endmodule
`default_nettype wire

// File: hdl/rau_back.sv
`default_nettype none
module rau_back
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  item_t            q_item,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [127:0]     out_tdata,
  output logic             out_tuser
);
  bst_t        st_r, st_nxt;
  logic [1:0]  opi_r, opi_nxt;     // operand 0 = a, 1 = b
  logic [1:0]  mode_r;
  logic        an_r, bn_r, neg_r;
  logic [63:0] an_v_r, ad_v_r, bn_v_r, bd_v_r;
  logic [63:0] num_r, den_r, g_r, t1_r, t2_r;
  logic [63:0] onum_r, oden_r;
  logic        oerr_r, ovalid_r;
  logic        start_g, start_d, gdone;
  logic [63:0] gx, gy, gres;
  logic        s1, s2;

  rau_gcd u_gcd (
    .clk, .rst_n, .start_g, .start_d, .x(gx), .y(gy), .done(gdone), .res(gres)
  );

  assign q_ready    = (st_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, oden_r[62:0], onum_r};
  assign out_tuser  = oerr_r;
  assign s1 = an_r;
  assign s2 = (mode_r == OP_SUB) ? !bn_r : bn_r;

  always_comb begin
    st_nxt = st_r; opi_nxt = opi_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin st_nxt = ST_OPG; opi_nxt = 2'd0; end
      ST_OPG:  if (gdone) st_nxt = (gres == 0) ? ((opi_r == 2'd0) ? ST_OPG : ST_MUL1)
                                               : ST_OPDN;
      ST_OPDN: if (gdone) st_nxt = ST_OPDD;
      ST_OPDD: if (gdone) st_nxt = (opi_r == 2'd0) ? ST_OPG : ST_MUL1;
      ST_MUL1: st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_COMB;
      ST_COMB: st_nxt = ST_RG;
      ST_RG:   if (gdone) st_nxt = (gres == 0) ? ST_OUT : ST_RDN;
      ST_RDN:  if (gdone) st_nxt = ST_RDD;
      ST_RDD:  if (gdone) st_nxt = ST_OUT;
      ST_OUT:  if (!ovalid_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if ((st_r == ST_OPG && gdone && gres == 0 && opi_r == 2'd0) ||
        (st_r == ST_OPDD && gdone && opi_r == 2'd0)) opi_nxt = 2'd1;
  end

  // unit starts: fire on entry to each phase
  always_comb begin
    start_g = 1'b0; start_d = 1'b0; gx = '0; gy = '0;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        start_g = 1'b1; gx = {32'd0, q_item.a_num}; gy = {32'd0, q_item.a_den};
      end
      ST_OPG: if (gdone) begin
        if (gres != 0) begin
          start_d = 1'b1; gx = (opi_r == 2'd0) ? an_v_r : bn_v_r; gy = gres;
        end else if (opi_r == 2'd0) begin
          start_g = 1'b1; gx = bn_v_r; gy = bd_v_r;
        end
      end
      ST_OPDN: if (gdone) begin
        start_d = 1'b1; gx = (opi_r == 2'd0) ? ad_v_r : bd_v_r; gy = g_r;
      end
      ST_OPDD: if (gdone && opi_r == 2'd0) begin
        start_g = 1'b1; gx = bn_v_r; gy = bd_v_r;
      end
      ST_COMB: begin start_g = 1'b1; gx = num_r; gy = den_r; end
      ST_RG: if (gdone && gres != 0) begin start_d = 1'b1; gx = num_r; gy = gres; end
      ST_RDN: if (gdone) begin start_d = 1'b1; gx = den_r; gy = g_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; opi_r <= 2'd0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; opi_r <= opi_nxt;
      if (st_r == ST_OUT && !ovalid_r) ovalid_r <= 1'b0;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      else if ((st_r == ST_RG && gdone && gres == 0) || (st_r == ST_RDD && gdone))
        ovalid_r <= 1'b1;
    end
    if (st_r == ST_IDLE && q_valid) begin
      mode_r <= q_item.mode; an_r <= q_item.a_neg; bn_r <= q_item.b_neg;
      an_v_r <= {32'd0, q_item.a_num}; ad_v_r <= {32'd0, q_item.a_den};
      bn_v_r <= {32'd0, q_item.b_num}; bd_v_r <= {32'd0, q_item.b_den};
    end
    if ((st_r == ST_OPG || st_r == ST_RG) && gdone) g_r <= gres;
    if (st_r == ST_OPG && gdone && gres == 0) begin
      if (opi_r == 2'd0) an_r <= 1'b0; else bn_r <= 1'b0;
    end
    if (st_r == ST_OPDN && gdone) begin
      if (opi_r == 2'd0) begin an_v_r <= gres; if (gres == 0) an_r <= 1'b0; end
      else begin bn_v_r <= gres; if (gres == 0) bn_r <= 1'b0; end
    end
    if (st_r == ST_OPDD && gdone) begin
      if (opi_r == 2'd0) ad_v_r <= gres; else bd_v_r <= gres;
    end
    // operand magnitudes are below 2^32 so each product fits 32x32
    if (st_r == ST_MUL1) begin
      unique case (mode_r)
        OP_MUL:  begin t1_r <= an_v_r[31:0] * bn_v_r[31:0]; neg_r <= an_r ^ bn_r; end
        OP_DIV:  begin t1_r <= an_v_r[31:0] * bd_v_r[31:0]; neg_r <= an_r ^ bn_r; end
        default: t1_r <= an_v_r[31:0] * bd_v_r[31:0];
      endcase
      t2_r <= bn_v_r[31:0] * ad_v_r[31:0];
    end
    if (st_r == ST_MUL2) begin
      den_r <= (mode_r == OP_DIV) ? ad_v_r[31:0] * bn_v_r[31:0]
                                  : ad_v_r[31:0] * bd_v_r[31:0];
    end
    // settle the numerator in ST_MUL2, ahead of the result gcd start in ST_COMB
    if (st_r == ST_MUL2) begin
      if (mode_r == OP_MUL || mode_r == OP_DIV) num_r <= t1_r;
      else if (s1 == s2) begin num_r <= t1_r + t2_r; neg_r <= s1; end
      else if (t1_r >= t2_r) begin num_r <= t1_r - t2_r; neg_r <= s1; end
      else begin num_r <= t2_r - t1_r; neg_r <= s2; end
    end
    if (st_r == ST_RG && gdone && gres == 0) begin
      onum_r <= '0; oden_r <= '0; oerr_r <= 1'b1;
    end
    if (st_r == ST_RDN && gdone) num_r <= gres;
    if (st_r == ST_RDD && gdone) begin
      onum_r <= (neg_r && num_r != 0) ? 64'(-num_r) : num_r;
      oden_r <= gres; oerr_r <= (gres == 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r)
    else $error("result dropped");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !ovalid_r)
    else $error("idle with pending result");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready && q_valid |=> st_r == ST_OPG)
    else $error("item not taken");
endmodule
`default_nettype wire

// File: hdl/rational_arith_unit.sv
`default_nettype none
// The run time of an item is set by the shared gcd/divide unit: a binary gcd
// per operand and one on the result, and six exact divides; an operand or
// result of 0/0 skips its two divides. The back end takes one item at a time,
// and the next starts only after a result is taken; a 2-entry queue in front
// accepts up to two more. Reset: rst_n synchronous, active low; clears the
// queue and control state.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  wire logic [1:0]   in_tuser,   // mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // res_num, res_den, zero pad bit
  output logic              out_tuser   // zero_den_error
);
  logic  q_valid, q_ready;
  item_t q_item;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_ready, .q_item
  );

  rau_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               err;
  } ratio_res_t;

  // Operand reduced to sign and magnitude, denominator non-negative.
  typedef struct {
    logic        neg;
    logic [63:0] num;
    logic [63:0] den;
  } smag_t;

  class ratio_board;
    ratio_res_t pending[$];
    int         errors;

    function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function smag_t reduce(logic neg, logic [63:0] n, logic [63:0] d);
      smag_t       r;
      logic [63:0] g;
      g = gcd64(n, d);
      if (g != 0) begin
        n = n / g;
        d = d / g;
      end
      r.neg = (n == 0) ? 1'b0 : neg;
      r.num = n;
      r.den = d;
      return r;
    endfunction

    function logic [63:0] mag(logic [31:0] v);
      return v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
    endfunction

    function void note_operands(op_t op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
      smag_t       a, b, r;
      logic [63:0] t1, t2, n, d;
      logic        s1, s2, ng;
      ratio_res_t  e;
      a = reduce(an[31] != ad[31], mag(an), mag(ad));
      b = reduce(bn[31] != bd[31], mag(bn), mag(bd));
      case (op)
        OP_ADD, OP_SUB: begin
          t1 = a.num * b.den;
          t2 = b.num * a.den;
          s1 = a.neg;
          s2 = (op == OP_SUB) ? !b.neg : b.neg;
          if (s1 == s2) begin
            n = t1 + t2; ng = s1;
          end else if (t1 >= t2) begin
            n = t1 - t2; ng = s1;
          end else begin
            n = t2 - t1; ng = s2;
          end
          d = a.den * b.den;
        end
        OP_MUL: begin
          n = a.num * b.num; d = a.den * b.den; ng = a.neg != b.neg;
        end
        default: begin
          n = a.num * b.den; d = a.den * b.num; ng = a.neg != b.neg;
        end
      endcase
      r = reduce(ng, n, d);
      e.num = r.neg ? -r.num : r.num;
      e.den = r.den[62:0];
      e.err = (r.den == 0);
      pending.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] exp_v);
      $display("error: %s got %h expected %h", what, got, exp_v);
      errors++;
    endtask

    task check_result(logic [127:0] data, logic user);
      ratio_res_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", data[63:0], 64'd0);
        return;
      end
      e = pending.pop_front();
      if (data[63:0] !== e.num) report("res_num", data[63:0], e.num);
      if (data[126:64] !== e.den) report("res_den", {1'b0, data[126:64]}, {1'b0, e.den});
      if (data[127] !== 1'b0) report("pad bit", {63'd0, data[127]}, 64'd0);
      if (user !== e.err) report("zero_den_error", {63'd0, user}, {63'd0, e.err});
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;

  ratio_board board = new();
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_off = 0;
  longint     cycles = 0;

  rational_arith_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  // receiver: random stalls, or a long hold-off while hold_off runs down
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
      4, 5: return $signed($urandom_range(40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  // returns at the accepting edge; valid stays up for a following beat
  task send_beat(op_t op, logic [31:0] an, logic [31:0] ad,
                 logic [31:0] bn, logic [31:0] bd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_operands(op, an, ad, bn, bd);
  endtask

  task send_random(int count);
    logic [31:0] ad, bd;
    repeat (count) begin
      ad = rand_val();
      bd = rand_val();
      // mostly valid denominators, zero now and then
      if (ad == 0 && $urandom_range(3) != 0) ad = 32'd7;
      if (bd == 0 && $urandom_range(3) != 0) bd = 32'hffff_fff3;
      send_beat(op_t'($urandom_range(3)), rand_val(), ad, rand_val(), bd);
    end
  endtask

  task drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_beat(op_t'(i), 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(op_t'(i), 32'd3, 32'd6, 32'hffff_fffe, 32'd4);
      send_beat(op_t'(i), 32'd0, 32'hffff_fffb, 32'd5, 32'd0);
      send_beat(op_t'(i), 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd9);
    end
    send_beat(OP_DIV, 32'd5, 32'd3, 32'd7, 32'd0);
    send_beat(OP_ADD, 32'd1, 32'd2, 32'hffff_ffff, 32'd2);
    send_beat(OP_SUB, 32'h5555_aaaa, 32'haaaa_5555, 32'h5555_aaaa, 32'haaaa_5555);
    // fill the queue while the receiver holds off
    hold_off = 3000;
    send_random(5);
    send_random(245);
    drain();
    send_idle_pct = 77;
    send_random(250);
    drain();
    send_idle_pct = 0;
    stall_pct = 77;
    send_random(250);
    drain();
    send_idle_pct = 35;
    stall_pct = 35;
    send_random(250);
    drain();
    repeat (1000) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
